FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clock, resetn, prop) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clock, resetn, expr) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clock, resetn, prop)

`define ASSERT_NEVER(label, clock, resetn, expr)

`endif

`endif

FILE: hdl/mctk_pkg.sv
// ----------------------------------------------------------------------------
// mctk_pkg
// Types, constants and the fixed Morse code table of the character keyer.
// ----------------------------------------------------------------------------
`default_nettype none

package mctk_pkg;

    localparam int TABLE_ENTRIES = 48;
    localparam int TABLE_SLOTS   = 64;
    localparam int IDX_W         = $clog2(TABLE_SLOTS);

    localparam int TICK_W  = 32;
    localparam int CHAR_W  = 8;
    localparam int PAT_W   = 8;
    localparam int CNT_W   = 3;
    localparam int CFG_W   = 3;
    localparam int OUT_W   = 40;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Register indexes of the configuration port.
    localparam logic [CFG_W-1:0] REG_DIT       = 3'd0;
    localparam logic [CFG_W-1:0] REG_DAH       = 3'd1;
    localparam logic [CFG_W-1:0] REG_ELEM_GAP  = 3'd2;
    localparam logic [CFG_W-1:0] REG_CHAR_GAP  = 3'd3;
    localparam logic [CFG_W-1:0] REG_WORD_GAP  = 3'd4;

    localparam logic [TICK_W-1:0] DIT_RESET       = 32'd13333333;
    localparam logic [TICK_W-1:0] DAH_RESET       = 32'd53333332;
    localparam logic [TICK_W-1:0] ELEM_GAP_RESET  = 32'd17333332;
    localparam logic [TICK_W-1:0] CHAR_GAP_RESET  = 32'd69333331;
    localparam logic [TICK_W-1:0] WORD_GAP_RESET  = 32'd207999994;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [PAT_W-1:0]  pattern;
        logic [CNT_W-1:0]  count;
    } entry_t;

    typedef struct packed {
        logic              hit;
        logic [PAT_W-1:0]  pattern;
        logic [CNT_W-1:0]  count;
    } lookup_t;

    // Pattern is sent most significant bit first, a one is a dah.
    // A count of zero marks an empty slot.
    function automatic entry_t code_entry(input logic [IDX_W-1:0] idx);
        entry_t e;
        case (idx)
            6'd0:    e = '{"A", 8'h40, 3'd2};
            6'd1:    e = '{"B", 8'h80, 3'd4};
            6'd2:    e = '{"C", 8'hA0, 3'd4};
            6'd3:    e = '{"D", 8'h80, 3'd3};
            6'd4:    e = '{"E", 8'h00, 3'd1};
            6'd5:    e = '{"F", 8'h20, 3'd4};
            6'd6:    e = '{"G", 8'hC0, 3'd3};
            6'd7:    e = '{"H", 8'h00, 3'd4};
            6'd8:    e = '{"I", 8'h00, 3'd2};
            6'd9:    e = '{"J", 8'h70, 3'd4};
            6'd10:   e = '{"K", 8'hA0, 3'd3};
            6'd11:   e = '{"L", 8'h40, 3'd4};
            6'd12:   e = '{"M", 8'hC0, 3'd2};
            6'd13:   e = '{"N", 8'h80, 3'd2};
            6'd14:   e = '{"O", 8'hE0, 3'd3};
            6'd15:   e = '{"P", 8'h60, 3'd4};
            6'd16:   e = '{"Q", 8'hD0, 3'd4};
            6'd17:   e = '{"R", 8'h40, 3'd3};
            6'd18:   e = '{"S", 8'h00, 3'd3};
            6'd19:   e = '{"T", 8'h80, 3'd1};
            6'd20:   e = '{"U", 8'h20, 3'd3};
            6'd21:   e = '{"V", 8'h10, 3'd4};
            6'd22:   e = '{"W", 8'h60, 3'd3};
            6'd23:   e = '{"X", 8'h90, 3'd4};
            6'd24:   e = '{"Y", 8'hB0, 3'd4};
            6'd25:   e = '{"Z", 8'hC0, 3'd4};
            6'd26:   e = '{"0", 8'hF8, 3'd5};
            6'd27:   e = '{"1", 8'h78, 3'd5};
            6'd28:   e = '{"2", 8'h38, 3'd5};
            6'd29:   e = '{"3", 8'h18, 3'd5};
            6'd30:   e = '{"4", 8'h08, 3'd5};
            6'd31:   e = '{"5", 8'h00, 3'd5};
            6'd32:   e = '{"6", 8'h80, 3'd5};
            6'd33:   e = '{"7", 8'hC0, 3'd5};
            6'd34:   e = '{"8", 8'hE0, 3'd5};
            6'd35:   e = '{"9", 8'hF0, 3'd5};
            6'd36:   e = '{".", 8'h54, 3'd6};
            6'd37:   e = '{",", 8'hCC, 3'd6};
            6'd38:   e = '{"?", 8'h30, 3'd6};
            6'd39:   e = '{"-", 8'h84, 3'd6};
            6'd40:   e = '{"@", 8'h68, 3'd6};
            6'd41:   e = '{"_", 8'h34, 3'd6};
            6'd42:   e = '{"+", 8'h50, 3'd5};
            6'd43:   e = '{";", 8'hA8, 3'd6};
            6'd44:   e = '{"&", 8'h40, 3'd5};
            6'd45:   e = '{"/", 8'h90, 3'd5};
            6'd46:   e = '{"(", 8'hB0, 3'd5};
            6'd47:   e = '{")", 8'hB4, 3'd6};
            default: e = '{8'h00, 8'h00, 3'd0};
        endcase
        return e;
    endfunction

    // First matching entry among the searched slots.
    function automatic lookup_t code_lookup(input logic [CHAR_W-1:0] ch);
        lookup_t r;
        entry_t  e;
        r = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            e = code_entry(IDX_W'(i));
            if (!r.hit && e.count != '0 && e.ch == ch)
            begin
                r.hit     = 1'b1;
                r.pattern = e.pattern;
                r.count   = e.count;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/morse_char_timed_keyer.sv
// ----------------------------------------------------------------------------
// morse_char_timed_keyer
// Turns one ASCII character into a run of timed pin-level segments.
// ----------------------------------------------------------------------------
// Usage:
// A character enters on the s_ stream. Each result word on the m_ stream is
// one segment: a pin level and the number of clock ticks to hold it, with
// tlast on the final segment of the character. A letter of N elements gives
// 2N+1 words: mark, element gap, ..., then the character gap. A space gives
// a single word gap word; a character not in the table gives no words.
// The pattern shift register steps one element bit per mark word and one
// word is loaded per cycle while the output register can advance. After
// acceptance the sequencer state is registered first, then the first word
// is loaded into the output register. A new character is taken once the
// last word of the previous one sits in the output register. When the
// receiver stalls, the output register holds its word and the sequencer
// waits.
// Timing registers are written on the cfg channel, which is always ready;
// write them only while the block is idle. Reset loads the standard timing
// values and drops all pending words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module morse_char_timed_keyer
    import mctk_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // s_tdata: [7:0] char_code
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [CHAR_W-1:0]  s_tdata,
    // m_tdata: [0] pin_level, [32:1] duration_ticks, [39:33] zero
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [OUT_W-1:0]        m_tdata,
    output logic                    m_tlast,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_W-1:0]   cfg_index,
    input  wire logic [TICK_W-1:0]  cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MARK  = 5'b00010,
        ST_SPACE = 5'b00100,
        ST_CGAP  = 5'b01000,
        ST_WGAP  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [PAT_W-1:0]   pat_reg, pat_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TICK_W-1:0]  dit_reg, dah_reg, egap_reg, cgap_reg, wgap_reg;
    logic               ovalid_reg, ovalid_next;
    logic               olevel_reg, olevel_next;
    logic [TICK_W-1:0]  oticks_reg, oticks_next;
    logic               olast_reg, olast_next;
    logic               advance;
    logic               s_take;
    lookup_t            hit;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_take    = s_tvalid && s_tready;
    assign advance   = !ovalid_reg || m_tready;
    assign hit       = code_lookup(s_tdata);

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{(OUT_W - TICK_W - 1){1'b0}}, oticks_reg, olevel_reg};
    assign m_tlast  = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dit_reg  <= DIT_RESET;
            dah_reg  <= DAH_RESET;
            egap_reg <= ELEM_GAP_RESET;
            cgap_reg <= CHAR_GAP_RESET;
            wgap_reg <= WORD_GAP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DIT:      dit_reg  <= cfg_data;
                REG_DAH:      dah_reg  <= cfg_data;
                REG_ELEM_GAP: egap_reg <= cfg_data;
                REG_CHAR_GAP: cgap_reg <= cfg_data;
                REG_WORD_GAP: wgap_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pat_next    = pat_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && !m_tready;
        olevel_next = olevel_reg;
        oticks_next = oticks_reg;
        olast_next  = olast_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_take)
                begin
                    pat_next = hit.pattern;
                    cnt_next = hit.count;
                    if (s_tdata == CHAR_SPACE)
                        state_next = ST_WGAP;
                    else if (hit.hit)
                        state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                if (advance)
                begin
                    ovalid_next = 1'b1;
                    olevel_next = 1'b0;
                    oticks_next = pat_reg[PAT_W-1] ? dah_reg : dit_reg;
                    olast_next  = 1'b0;
                    pat_next    = {pat_reg[PAT_W-2:0], 1'b0};
                    state_next  = ST_SPACE;
                end
            end
            ST_SPACE:
            begin
                if (advance)
                begin
                    ovalid_next = 1'b1;
                    olevel_next = 1'b1;
                    oticks_next = egap_reg;
                    olast_next  = 1'b0;
                    cnt_next    = cnt_reg - CNT_W'(1);
                    state_next  = (cnt_reg == CNT_W'(1)) ? ST_CGAP : ST_MARK;
                end
            end
            ST_CGAP:
            begin
                if (advance)
                begin
                    ovalid_next = 1'b1;
                    olevel_next = 1'b1;
                    oticks_next = cgap_reg;
                    olast_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_WGAP:
            begin
                if (advance)
                begin
                    ovalid_next = 1'b1;
                    olevel_next = 1'b1;
                    oticks_next = wgap_reg;
                    olast_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg    <= pat_next;
        olevel_reg <= olevel_next;
        oticks_reg <= oticks_next;
        olast_reg  <= olast_next;
    end

    // An element gap is only ever emitted with elements still counted.
    `ASSERT_NEVER(a_space_cnt, clk, rst_n, state_reg == ST_SPACE && cnt_reg == '0)

    // The closing segment of any character is always a gap at level one.
    `ASSERT_CLK(a_last_gap, clk, rst_n, m_tvalid && m_tlast |-> m_tdata[0])

    // A space goes straight to the word gap.
    `ASSERT_CLK(a_space_wgap, clk, rst_n, s_take && s_tdata == CHAR_SPACE |=> state_reg == ST_WGAP)

endmodule

`default_nettype wire

FILE: verif/morse_char_timed_keyer_checker.sv
// ----------------------------------------------------------------------------
// morse_char_timed_keyer_checker
// Watches the character, segment and timing channels of the keyer. It keeps
// its own copy of the timing registers and of the Morse table, expands every
// accepted character into the segment words it must produce, and compares
// each segment word leaving the block against the oldest one still due.
// ----------------------------------------------------------------------------
module morse_char_timed_keyer_checker
    import mctk_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [CHAR_W-1:0]  s_tdata,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [OUT_W-1:0]   m_tdata,
    input  wire logic               m_tlast,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [CFG_W-1:0]   cfg_index,
    input  wire logic [TICK_W-1:0]  cfg_data,
    output int unsigned             fail_count,
    output int unsigned             segments_due
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              level;
        logic [TICK_W-1:0] ticks;
        logic              last;
    } segment_t;

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [CNT_W-1:0] count;
    } symbol_t;

    segment_t          segment_q[$];
    logic [TICK_W-1:0] dit_len;
    logic [TICK_W-1:0] dah_len;
    logic [TICK_W-1:0] elem_gap_len;
    logic [TICK_W-1:0] char_gap_len;
    logic [TICK_W-1:0] word_gap_len;

    // Elements are keyed from the top pattern bit down, a one is a dah.
    // A count of zero means the character has no code.
    function automatic symbol_t morse_symbol(input logic [CHAR_W-1:0] ch);
        symbol_t s;
        case (ch)
            "A":     s = '{8'h40, 3'd2};
            "B":     s = '{8'h80, 3'd4};
            "C":     s = '{8'hA0, 3'd4};
            "D":     s = '{8'h80, 3'd3};
            "E":     s = '{8'h00, 3'd1};
            "F":     s = '{8'h20, 3'd4};
            "G":     s = '{8'hC0, 3'd3};
            "H":     s = '{8'h00, 3'd4};
            "I":     s = '{8'h00, 3'd2};
            "J":     s = '{8'h70, 3'd4};
            "K":     s = '{8'hA0, 3'd3};
            "L":     s = '{8'h40, 3'd4};
            "M":     s = '{8'hC0, 3'd2};
            "N":     s = '{8'h80, 3'd2};
            "O":     s = '{8'hE0, 3'd3};
            "P":     s = '{8'h60, 3'd4};
            "Q":     s = '{8'hD0, 3'd4};
            "R":     s = '{8'h40, 3'd3};
            "S":     s = '{8'h00, 3'd3};
            "T":     s = '{8'h80, 3'd1};
            "U":     s = '{8'h20, 3'd3};
            "V":     s = '{8'h10, 3'd4};
            "W":     s = '{8'h60, 3'd3};
            "X":     s = '{8'h90, 3'd4};
            "Y":     s = '{8'hB0, 3'd4};
            "Z":     s = '{8'hC0, 3'd4};
            "0":     s = '{8'hF8, 3'd5};
            "1":     s = '{8'h78, 3'd5};
            "2":     s = '{8'h38, 3'd5};
            "3":     s = '{8'h18, 3'd5};
            "4":     s = '{8'h08, 3'd5};
            "5":     s = '{8'h00, 3'd5};
            "6":     s = '{8'h80, 3'd5};
            "7":     s = '{8'hC0, 3'd5};
            "8":     s = '{8'hE0, 3'd5};
            "9":     s = '{8'hF0, 3'd5};
            ".":     s = '{8'h54, 3'd6};
            ",":     s = '{8'hCC, 3'd6};
            "?":     s = '{8'h30, 3'd6};
            "-":     s = '{8'h84, 3'd6};
            "@":     s = '{8'h68, 3'd6};
            "_":     s = '{8'h34, 3'd6};
            "+":     s = '{8'h50, 3'd5};
            ";":     s = '{8'hA8, 3'd6};
            "&":     s = '{8'h40, 3'd5};
            "/":     s = '{8'h90, 3'd5};
            "(":     s = '{8'hB0, 3'd5};
            ")":     s = '{8'hB4, 3'd6};
            default: s = '{8'h00, 3'd0};
        endcase
        return s;
    endfunction

    task automatic expand_char(input logic [CHAR_W-1:0] ch);
        symbol_t          sym;
        logic [PAT_W-1:0] pat;
        sym = morse_symbol(ch);
        pat = sym.pattern;
        if (ch == CHAR_SPACE)
            segment_q.push_back('{1'b1, word_gap_len, 1'b1});
        else if (sym.count != '0)
        begin
            for (int k = 0; k < int'(sym.count); k++)
            begin
                segment_q.push_back('{1'b0, pat[PAT_W-1] ? dah_len : dit_len, 1'b0});
                segment_q.push_back('{1'b1, elem_gap_len, 1'b0});
                pat = pat << 1;
            end
            segment_q.push_back('{1'b1, char_gap_len, 1'b1});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        segment_t want;
        if (!rst_n)
        begin
            segment_q.delete();
            dit_len      = DIT_RESET;
            dah_len      = DAH_RESET;
            elem_gap_len = ELEM_GAP_RESET;
            char_gap_len = CHAR_GAP_RESET;
            word_gap_len = WORD_GAP_RESET;
            fail_count   = 0;
        end
        else
        begin
            // Writes to an index past the last register are dropped.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DIT:      dit_len      = cfg_data;
                    REG_DAH:      dah_len      = cfg_data;
                    REG_ELEM_GAP: elem_gap_len = cfg_data;
                    REG_CHAR_GAP: char_gap_len = cfg_data;
                    REG_WORD_GAP: word_gap_len = cfg_data;
                    default:      ;
                endcase
            end
            if (s_tvalid && s_tready)
                expand_char(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (segment_q.size() == 0)
                begin
                    $error("segment word with none due: tdata %h tlast %b", m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = segment_q.pop_front();
                    if (m_tdata[0] !== want.level)
                    begin
                        $error("pin_level: expected %0d, actual %0d", want.level, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[TICK_W:1] !== want.ticks)
                    begin
                        $error("duration_ticks: expected %0d, actual %0d",
                               want.ticks, m_tdata[TICK_W:1]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_segment: expected %0d, actual %0d", want.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[OUT_W-1:TICK_W+1] !== '0)
                    begin
                        $error("tdata padding: expected %0d, actual %0d",
                               0, m_tdata[OUT_W-1:TICK_W+1]);
                        fail_count++;
                    end
                end
            end
        end
        segments_due = segment_q.size();
    end

endmodule

FILE: verif/morse_char_timed_keyer_tb.sv
// ----------------------------------------------------------------------------
// morse_char_timed_keyer_tb
// Drives characters and timing writes into the keyer and gives the verdict.
// A directed set of characters runs with the reset timing, then several
// random phases run with timing that goes from all zeros to all ones to
// mixed values, with random stalls on both streams, one long output stall
// and a final phase with no stalls. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module morse_char_timed_keyer_tb
    import mctk_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int PHASES          = 5;
    localparam int PHASE_CHARS     = 36;

    // Every character that has a code, in table order from the top byte down.
    localparam logic [8*TABLE_ENTRIES-1:0] KEYED_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?-@_+;&/()";

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_index = '0;
    logic [TICK_W-1:0]  cfg_data  = '0;

    int unsigned        fail_count;
    int unsigned        segments_due;

    bit                 source_idle = 1'b1;
    bit                 sink_idle   = 1'b1;
    bit                 long_hold   = 1'b0;

    morse_char_timed_keyer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    morse_char_timed_keyer_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .segments_due (segments_due)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // The word stays offered until taken; tvalid is only dropped for a gap.
    task automatic send_char(input logic [CHAR_W-1:0] ch);
        if (source_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Unknown characters leave no trace on the output, so after the last
    // segment word the block gets a few more cycles to finish. The count of
    // due words is looked at mid-cycle, once the checker has updated it.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (segments_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_timing(input logic [TICK_W-1:0] dit, input logic [TICK_W-1:0] dah,
                                  input logic [TICK_W-1:0] elem_gap,
                                  input logic [TICK_W-1:0] char_gap,
                                  input logic [TICK_W-1:0] word_gap);
        // An index past the last register must leave the timing alone.
        write_reg(REG_WORD_GAP + CFG_W'($urandom_range(1, 3)), $urandom);
        write_reg(REG_DIT, dit);
        write_reg(REG_DAH, dah);
        write_reg(REG_ELEM_GAP, elem_gap);
        write_reg(REG_CHAR_GAP, char_gap);
        write_reg(REG_WORD_GAP, word_gap);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [TICK_W-1:0] pick_ticks();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return TICK_W'($urandom_range(1, 20));
            default: return $urandom;
        endcase
    endfunction

    // Mostly characters with a code, some spaces and some arbitrary bytes.
    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return CHAR_SPACE;
            1:       return CHAR_W'($urandom_range(0, 255));
            default: return KEYED_CHARS[8*$urandom_range(0, TABLE_ENTRIES-1) +: 8];
        endcase
    endfunction

    initial
    begin
        string directed;
        directed = "ETAM05-),? ";
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing: single-element letters, all dahs, all dits, the
        // hyphen, the last table entry, a space and several codes with none.
        for (int i = 0; i < directed.len(); i++)
            send_char(directed[i]);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h80);
        send_char("a");
        send_char("!");
        send_char(CHAR_SPACE);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0:       program_timing('0, '0, '0, '0, '0);
                1:       program_timing('1, '1, '1, '1, '1);
                default: program_timing(pick_ticks(), pick_ticks(), pick_ticks(),
                                        pick_ticks(), pick_ticks());
            endcase
            sink_idle = (p != PHASES - 1);
            if (p == 2)
                long_hold = 1'b1;
            for (int i = 0; i < PHASE_CHARS; i++)
            begin
                // During the long output stall the source keeps pushing.
                source_idle = !(p == 2 && i < 24) && (p != PHASES - 1);
                send_char(pick_char());
            end
        end
        settle();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_CYCLES)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
